// ===== rtl/cpcr_pkg.sv =====
`default_nettype none
package cpcr_pkg;

    // Square root: 46-bit radicand (squared distance in Q.12), 23-bit root (distance in Q.6).
    localparam int SQ_IN_W = 46;
    localparam int SQ_W    = 23;
    localparam int SQ_REM_W = SQ_W + 3;

    // Divider: 40-bit numerator, 23-bit divisor, 16 quotient bits.
    localparam int NUM_W   = 40;
    localparam int DEN_W   = SQ_W;
    localparam int DIV_QW  = 16;
    localparam int DREM_W  = NUM_W - DIV_QW;

    // Geometry and fixed-point constants.
    localparam int unsigned MIN_D2     = 66;
    localparam int unsigned NORMAL_ONE = 16384;
    localparam int unsigned E_MAX      = 256;

    // Register map (word index).
    localparam logic [2:0] REG_RESTITUTION = 3'd0;
    localparam logic [8:0] RESTITUTION_RST = 9'd192;

    // Per-item state carried alongside the square root and the divider.
    typedef struct packed {
        logic signed [18:0] x1;
        logic signed [18:0] y1;
        logic signed [15:0] vx1;
        logic signed [15:0] vy1;
        logic signed [18:0] x2;
        logic signed [18:0] y2;
        logic signed [15:0] vx2;
        logic signed [15:0] vy2;
        logic               contact;
        logic        [16:0] sr;
        logic               dx_neg;
        logic               dy_neg;
        logic        [18:0] dx_mag;
        logic        [18:0] dy_mag;
    } t_side;

    // Round half away from zero, shift by 21.
    function automatic logic signed [18:0] f_rnd21(input logic signed [40:0] v);
        logic [40:0] m;
        logic [40:0] r;
        m = v[40] ? 41'(-v) : 41'(v);
        r = (m + 41'(1 << 20)) >> 21;
        return v[40] ? -19'(signed'(r[18:0])) : 19'(signed'(r[18:0]));
    endfunction

    // Round half away from zero, shift by 37.
    function automatic logic signed [22:0] f_rnd37(input logic signed [59:0] v);
        logic [59:0] m;
        logic [59:0] r;
        m = v[59] ? 60'(-v) : 60'(v);
        r = (m + (60'(1) << 36)) >> 37;
        return v[59] ? -23'(signed'(r[22:0])) : 23'(signed'(r[22:0]));
    endfunction

    function automatic logic signed [18:0] f_sat19(input logic signed [20:0] v);
        if (v > 21'sd262143) begin
            return 19'sd262143;
        end else if (v < -21'sd262144) begin
            return -19'sd262144;
        end
        return v[18:0];
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [24:0] v);
        if (v > 25'sd32767) begin
            return 16'sd32767;
        end else if (v < -25'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cpcr_sqrt.sv =====
`default_nettype none
module cpcr_sqrt import cpcr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [SQ_IN_W-1:0] i_x,
    input  wire t_side              i_side,
    output logic                    o_valid,
    output logic [SQ_W-1:0]         o_root,
    output t_side                   o_side
);

    logic                r_v    [SQ_W];
    logic [SQ_IN_W-1:0]  r_xs   [SQ_W];
    logic [SQ_REM_W-1:0] r_rem  [SQ_W];
    logic [SQ_W-1:0]     r_root [SQ_W];
    t_side               r_side [SQ_W];

    // One root bit per stage, restoring digit-by-digit method.
    for (genvar g = 0; g < SQ_W; g++) begin : g_stage
        logic                v_in;
        logic [SQ_IN_W-1:0]  xs_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [SQ_W-1:0]     root_in;
        t_side               side_in;
        logic [SQ_REM_W-1:0] trial;
        logic [SQ_REM_W-1:0] test;
        logic [SQ_REM_W-1:0] n_rem;
        logic [SQ_W-1:0]     n_root;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign xs_in   = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign xs_in   = r_xs[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign side_in = r_side[g-1];
        end

        always_comb begin
            trial = {rem_in[SQ_REM_W-3:0], xs_in[SQ_IN_W-1 -: 2]};
            test  = SQ_REM_W'({root_in, 2'b01});
            if (trial >= test) begin
                n_rem  = trial - test;
                n_root = {root_in[SQ_W-2:0], 1'b1};
            end else begin
                n_rem  = trial;
                n_root = {root_in[SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_xs[g]   <= {xs_in[SQ_IN_W-3:0], 2'b00};
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_v[SQ_W-1];
    assign o_root  = r_root[SQ_W-1];
    assign o_side  = r_side[SQ_W-1];

endmodule
`default_nettype wire

// ===== rtl/cpcr_div.sv =====
`default_nettype none
module cpcr_div import cpcr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic      [DIV_QW-1:0] o_q
);

    logic [DIV_QW-1:0] r_lo  [DIV_QW];
    logic [DREM_W-1:0] r_rem [DIV_QW];
    logic [DEN_W-1:0]  r_den [DIV_QW];
    logic [DIV_QW-1:0] r_q   [DIV_QW];

    // One quotient bit per stage, restoring division.
    for (genvar g = 0; g < DIV_QW; g++) begin : g_stage
        logic [DIV_QW-1:0] lo_in;
        logic [DREM_W-1:0] rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [DIV_QW-1:0] q_in;
        logic [DREM_W:0]   trial;
        logic [DREM_W-1:0] n_rem;
        logic              qbit;

        if (g == 0) begin : g_first
            assign lo_in  = i_num[DIV_QW-1:0];
            assign rem_in = i_num[NUM_W-1:DIV_QW];
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign lo_in  = r_lo[g-1];
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign q_in   = r_q[g-1];
        end

        always_comb begin
            trial = {rem_in, lo_in[DIV_QW-1]};
            if (trial >= (DREM_W+1)'(den_in)) begin
                n_rem = DREM_W'(trial - (DREM_W+1)'(den_in));
                qbit  = 1'b1;
            end else begin
                n_rem = trial[DREM_W-1:0];
                qbit  = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[g]  <= {lo_in[DIV_QW-2:0], 1'b0};
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
                r_q[g]   <= {q_in[DIV_QW-2:0], qbit};
            end
        end
    end

    assign o_q = r_q[DIV_QW-1];

endmodule
`default_nettype wire

// ===== rtl/circle_pair_collision_response.sv =====
// Circle pair collision response.
// Requests arrive on the slave stream (i_s_tvalid / o_s_tready / i_s_tdata), one circle pair
// per request, and leave on the master stream with the separated positions and exchanged
// velocities in o_m_tdata and the contact and impact flags in o_m_tuser.
// The restitution coefficient (Q1.8, values above 256 act as 256) is written through the
// APB port at address 0; write it only while no request is in flight.
// Throughput is one request per cycle while the receiver takes results: the pipeline holds
// two input stages, a 23-stage square root (one root bit per stage), a 16-stage pair of
// dividers for the unit normal (one quotient bit per stage), and six stages of multiplies,
// rounding and saturation ending in the output register.
// Reset clears all valid bits and sets restitution to 192 (0.75).
// When the receiver stalls, the whole pipeline holds: o_s_tready falls while the output
// register holds a result that is not taken, and no request is lost or repeated.
`default_nettype none
module circle_pair_collision_response import cpcr_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // first_x, first_y, first_vx, first_vy, first_radius,
    // second_x, second_y, second_vx, second_vy, second_radius; zero padded
    input  wire logic [175:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // new_first_x, new_first_y, new_first_vx, new_first_vy, new_second_x, new_second_y,
    // new_second_vx, new_second_vy, normal_x, normal_y; zero padded
    output logic [175:0]      o_m_tdata,
    // contact, impact
    output logic [1:0]        o_m_tuser,
    input  wire logic         i_psel,
    input  wire logic         i_penable,
    input  wire logic         i_pwrite,
    input  wire logic [2:0]   i_paddr,
    input  wire logic [31:0]  i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready
);

    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // Configuration register.
    logic [8:0] r_rest;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= RESTITUTION_RST;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr == REG_RESTITUTION) begin
            r_rest <= i_pwdata[8:0];
        end
    end
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == REG_RESTITUTION) ? {23'd0, r_rest} : 32'd0;

    // Stage 1: unpack and take differences.
    logic               r1_v;
    t_side              r1_s;
    logic signed [19:0] r1_dx, r1_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_s.x1  <= i_s_tdata[18:0];
            r1_s.y1  <= i_s_tdata[37:19];
            r1_s.vx1 <= i_s_tdata[53:38];
            r1_s.vy1 <= i_s_tdata[69:54];
            r1_s.x2  <= i_s_tdata[104:86];
            r1_s.y2  <= i_s_tdata[123:105];
            r1_s.vx2 <= i_s_tdata[139:124];
            r1_s.vy2 <= i_s_tdata[155:140];
            r1_s.contact <= 1'b0;
            r1_s.sr  <= 17'(i_s_tdata[85:70]) + 17'(i_s_tdata[171:156]);
            r1_s.dx_neg <= 1'b0;
            r1_s.dy_neg <= 1'b0;
            r1_s.dx_mag <= '0;
            r1_s.dy_mag <= '0;
            r1_dx <= 20'(signed'(i_s_tdata[104:86])) - 20'(signed'(i_s_tdata[18:0]));
            r1_dy <= 20'(signed'(i_s_tdata[123:105])) - 20'(signed'(i_s_tdata[37:19]));
        end
    end

    // Stage 2: squared distance and squared radius sum.
    logic               r2_v;
    t_side              r2_s;
    logic signed [19:0] r2_dx, r2_dy;
    logic [39:0]        r2_d2;
    logic [33:0]        r2_ss;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_s  <= r1_s;
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_d2 <= 40'(r1_dx * r1_dx) + 40'(r1_dy * r1_dy);
            r2_ss <= r1_s.sr * r1_s.sr;
        end
    end

    // Contact test feeds the square root.
    t_side sq_side;
    always_comb begin
        sq_side         = r2_s;
        sq_side.contact = (r2_d2 < 40'(r2_ss)) && (r2_d2 >= 40'(MIN_D2));
        sq_side.dx_neg  = r2_dx[19];
        sq_side.dy_neg  = r2_dy[19];
        sq_side.dx_mag  = r2_dx[19] ? 19'(-r2_dx) : r2_dx[18:0];
        sq_side.dy_mag  = r2_dy[19] ? 19'(-r2_dy) : r2_dy[18:0];
    end

    logic            sq_v;
    logic [SQ_W-1:0] sq_root;
    t_side           sq_out;
    cpcr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_x     ({r2_d2[33:0], 12'd0}),
        .i_side  (sq_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_out)
    );

    // Normal components: rounded |d| * 2^20 / distance.
    logic [DIV_QW-1:0] qx, qy;
    cpcr_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({1'b0, sq_out.dx_mag, 20'd0} + NUM_W'(sq_root >> 1)),
        .i_den (sq_root),
        .o_q   (qx)
    );
    cpcr_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({1'b0, sq_out.dy_mag, 20'd0} + NUM_W'(sq_root >> 1)),
        .i_den (sq_root),
        .o_q   (qy)
    );

    // Delay line matching the divider depth.
    logic            r_dl_v    [DIV_QW];
    t_side           r_dl_s    [DIV_QW];
    logic [SQ_W-1:0] r_dl_root [DIV_QW];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_QW; k++) begin
                r_dl_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_dl_v[0] <= sq_v;
            for (int k = 1; k < DIV_QW; k++) begin
                r_dl_v[k] <= r_dl_v[k-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_s[0]    <= sq_out;
            r_dl_root[0] <= sq_root;
            for (int k = 1; k < DIV_QW; k++) begin
                r_dl_s[k]    <= r_dl_s[k-1];
                r_dl_root[k] <= r_dl_root[k-1];
            end
        end
    end

    // Stage N: clamp and sign the normal, form the overlap.
    logic               rn_v;
    t_side              rn_s;
    logic signed [15:0] rn_nx, rn_ny;
    logic [23:0]        rn_ov;
    logic [DIV_QW-1:0]  qx_c, qy_c;
    t_side              dl_last;
    assign dl_last = r_dl_s[DIV_QW-1];
    assign qx_c = (qx > DIV_QW'(NORMAL_ONE)) ? DIV_QW'(NORMAL_ONE) : qx;
    assign qy_c = (qy > DIV_QW'(NORMAL_ONE)) ? DIV_QW'(NORMAL_ONE) : qy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_v <= 1'b0;
        end else if (en) begin
            rn_v <= r_dl_v[DIV_QW-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            rn_s  <= dl_last;
            rn_nx <= dl_last.dx_neg ? -signed'(qx_c) : signed'(qx_c);
            rn_ny <= dl_last.dy_neg ? -signed'(qy_c) : signed'(qy_c);
            rn_ov <= {1'b0, dl_last.sr, 6'd0} - 24'(r_dl_root[DIV_QW-1]);
        end
    end

    // Stage M: shift and normal-velocity products.
    logic               rm_v;
    t_side              rm_s;
    logic signed [15:0] rm_nx, rm_ny;
    logic signed [40:0] rm_px, rm_py;
    logic signed [31:0] rm_a1, rm_b1, rm_a2, rm_b2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else if (en) begin
            rm_v <= rn_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_s  <= rn_s;
            rm_nx <= rn_nx;
            rm_ny <= rn_ny;
            rm_px <= 41'(rn_nx) * signed'({1'b0, rn_ov});
            rm_py <= 41'(rn_ny) * signed'({1'b0, rn_ov});
            rm_a1 <= 32'(rn_s.vx1) * 32'(rn_nx);
            rm_b1 <= 32'(rn_s.vy1) * 32'(rn_ny);
            rm_a2 <= 32'(rn_s.vx2) * 32'(rn_nx);
            rm_b2 <= 32'(rn_s.vy2) * 32'(rn_ny);
        end
    end

    // Stage R: round the shift, relative normal velocity.
    logic               rr_v;
    t_side              rr_s;
    logic signed [15:0] rr_nx, rr_ny;
    logic signed [18:0] rr_sx, rr_sy;
    logic signed [33:0] rr_rel;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rr_v <= 1'b0;
        end else if (en) begin
            rr_v <= rm_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            rr_s   <= rm_s;
            rr_nx  <= rm_nx;
            rr_ny  <= rm_ny;
            rr_sx  <= f_rnd21(rm_px);
            rr_sy  <= f_rnd21(rm_py);
            rr_rel <= (34'(rm_a1) + 34'(rm_b1)) - (34'(rm_a2) + 34'(rm_b2));
        end
    end

    // Stage J: impulse magnitude and separated positions.
    logic               rj_v;
    t_side              rj_s;
    logic signed [15:0] rj_nx, rj_ny;
    logic               rj_imp;
    logic [42:0]        rj_j;
    logic signed [18:0] rj_x1, rj_y1, rj_x2, rj_y2;
    logic [9:0]         e_sum;
    assign e_sum = 10'd256 + ((r_rest > 9'(E_MAX)) ? 10'(E_MAX) : 10'(r_rest));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rj_v <= 1'b0;
        end else if (en) begin
            rj_v <= rr_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            rj_s   <= rr_s;
            rj_nx  <= rr_nx;
            rj_ny  <= rr_ny;
            rj_imp <= rr_s.contact && (rr_rel > 34'sd0);
            rj_j   <= 43'(rr_rel[32:0]) * 43'(e_sum);
            rj_x1  <= f_sat19(21'(rr_s.x1) - 21'(rr_sx));
            rj_y1  <= f_sat19(21'(rr_s.y1) - 21'(rr_sy));
            rj_x2  <= f_sat19(21'(rr_s.x2) + 21'(rr_sx));
            rj_y2  <= f_sat19(21'(rr_s.y2) + 21'(rr_sy));
        end
    end

    // Stage K: impulse along the normal.
    logic               rk_v;
    t_side              rk_s;
    logic signed [15:0] rk_nx, rk_ny;
    logic               rk_imp;
    logic signed [59:0] rk_kx, rk_ky;
    logic signed [18:0] rk_x1, rk_y1, rk_x2, rk_y2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rk_v <= 1'b0;
        end else if (en) begin
            rk_v <= rj_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            rk_s   <= rj_s;
            rk_nx  <= rj_nx;
            rk_ny  <= rj_ny;
            rk_imp <= rj_imp;
            rk_kx  <= signed'({17'd0, rj_j}) * 60'(rj_nx);
            rk_ky  <= signed'({17'd0, rj_j}) * 60'(rj_ny);
            rk_x1  <= rj_x1;
            rk_y1  <= rj_y1;
            rk_x2  <= rj_x2;
            rk_y2  <= rj_y2;
        end
    end

    // Output register: velocity update and pass-through selection.
    logic signed [22:0] ddx, ddy;
    logic               c;
    assign ddx = f_rnd37(rk_kx);
    assign ddy = f_rnd37(rk_ky);
    assign c   = rk_s.contact;

    logic         r_out_v;
    logic [175:0] r_out_data;
    logic [1:0]   r_out_user;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= rk_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data[18:0]    <= c ? rk_x1 : rk_s.x1;
            r_out_data[37:19]   <= c ? rk_y1 : rk_s.y1;
            r_out_data[53:38]   <= rk_imp ? f_sat16(25'(rk_s.vx1) - 25'(ddx)) : rk_s.vx1;
            r_out_data[69:54]   <= rk_imp ? f_sat16(25'(rk_s.vy1) - 25'(ddy)) : rk_s.vy1;
            r_out_data[88:70]   <= c ? rk_x2 : rk_s.x2;
            r_out_data[107:89]  <= c ? rk_y2 : rk_s.y2;
            r_out_data[123:108] <= rk_imp ? f_sat16(25'(rk_s.vx2) + 25'(ddx)) : rk_s.vx2;
            r_out_data[139:124] <= rk_imp ? f_sat16(25'(rk_s.vy2) + 25'(ddy)) : rk_s.vy2;
            r_out_data[155:140] <= c ? rk_nx : 16'sd0;
            r_out_data[171:156] <= c ? rk_ny : 16'sd0;
            r_out_data[175:172] <= 4'd0;
            r_out_user          <= {rk_imp, c};
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
`default_nettype wire

// ===== rtl/cpcr_checker.sv =====
`default_nettype none
module cpcr_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [175:0] o_m_tdata,
    input wire logic [1:0]   o_m_tuser
);

    // A result held back by the receiver stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // An impact is only reported together with a contact.
    a_impact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tuser[0])
        else $error("impact without contact");

    // Without contact the normal is zero.
    a_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[171:140] == 32'd0)
        else $error("normal given without contact");

    // Input backpressure follows the output stall only.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted into a stalled pipeline");

endmodule

bind circle_pair_collision_response cpcr_checker u_cpcr_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
    logic signed [18:0] x1, y1;
    logic signed [15:0] vx1, vy1;
    logic        [15:0] r1;
    logic signed [18:0] x2, y2;
    logic signed [15:0] vx2, vy2;
    logic        [15:0] r2;
} t_pair;

typedef struct {
    logic [175:0] data;
    logic [1:0]   flags;
} t_response;

// Predicts the collision response of each accepted pair and checks results in order.
class collision_scoreboard;
    t_response pending[$];
    int unsigned restitution = 192;
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned contacts = 0;
    int unsigned impacts = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Rounds half away from zero; the value may need up to 64 bits of headroom.
    function automatic longint shift_round(longint v, int s);
        longint m;
        m = (mag(v) + (longint'(1) << (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    // Rounds a 128-bit product divided by 2^37.
    function automatic longint shift_round_wide(logic signed [127:0] v);
        logic signed [127:0] m;
        m = v < 0 ? -v : v;
        m = (m + (128'sd1 <<< 36)) >>> 37;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint root(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint d, longint dlen);
        longint q;
        q = ((mag(d) << 20) + (dlen >> 1)) / dlen;
        if (q > 16384) q = 16384;
        return d < 0 ? -q : q;
    endfunction

    function void note_request(t_pair p);
        longint x1, y1, vx1, vy1, x2, y2, vx2, vy2, dx, dy, d2, sr, nx, ny;
        longint dlen, ovl, sx, sy, rel, j, ddx, ddy, e;
        logic c, im;
        t_response rsp;
        x1 = p.x1; y1 = p.y1; vx1 = p.vx1; vy1 = p.vy1;
        x2 = p.x2; y2 = p.y2; vx2 = p.vx2; vy2 = p.vy2;
        nx = 0; ny = 0; c = 0; im = 0;
        dx = x2 - x1;
        dy = y2 - y1;
        d2 = dx * dx + dy * dy;
        sr = longint'(p.r1) + longint'(p.r2);
        if (d2 < sr * sr && d2 >= 66) begin
            c = 1;
            dlen = root(longint'(d2) << 12);
            ovl = (sr << 6) - dlen;
            nx = unit_part(dx, dlen);
            ny = unit_part(dy, dlen);
            sx = shift_round(nx * ovl, 21);
            sy = shift_round(ny * ovl, 21);
            x1 -= sx; y1 -= sy; x2 += sx; y2 += sy;
            rel = (vx1 * nx + vy1 * ny) - (vx2 * nx + vy2 * ny);
            if (rel > 0) begin
                im = 1;
                e = restitution > 256 ? 256 : restitution;
                j = rel * (256 + e);
                ddx = shift_round_wide(128'(signed'(j)) * 128'(signed'(nx)));
                ddy = shift_round_wide(128'(signed'(j)) * 128'(signed'(ny)));
                vx1 -= ddx; vy1 -= ddy; vx2 += ddx; vy2 += ddy;
            end
        end
        rsp.data = '0;
        rsp.data[18:0]    = 19'(clamp(x1, 19));
        rsp.data[37:19]   = 19'(clamp(y1, 19));
        rsp.data[53:38]   = 16'(clamp(vx1, 16));
        rsp.data[69:54]   = 16'(clamp(vy1, 16));
        rsp.data[88:70]   = 19'(clamp(x2, 19));
        rsp.data[107:89]  = 19'(clamp(y2, 19));
        rsp.data[123:108] = 16'(clamp(vx2, 16));
        rsp.data[139:124] = 16'(clamp(vy2, 16));
        rsp.data[155:140] = 16'(clamp(nx, 16));
        rsp.data[171:156] = 16'(clamp(ny, 16));
        rsp.flags = {im, c};
        contacts += c;
        impacts += im;
        pending.push_back(rsp);
    endfunction

    function void report(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d, want %0d", checked, what, got, want);
        errors++;
    endfunction

    function void check_result(logic [175:0] data, logic [1:0] flags);
        t_response w;
        if (pending.size() == 0) begin
            report("unexpected result", 1, 0);
            return;
        end
        w = pending.pop_front();
        if (data[18:0] !== w.data[18:0])
            report("new_first_x", signed'(data[18:0]), signed'(w.data[18:0]));
        if (data[37:19] !== w.data[37:19])
            report("new_first_y", signed'(data[37:19]), signed'(w.data[37:19]));
        if (data[53:38] !== w.data[53:38])
            report("new_first_vx", signed'(data[53:38]), signed'(w.data[53:38]));
        if (data[69:54] !== w.data[69:54])
            report("new_first_vy", signed'(data[69:54]), signed'(w.data[69:54]));
        if (data[88:70] !== w.data[88:70])
            report("new_second_x", signed'(data[88:70]), signed'(w.data[88:70]));
        if (data[107:89] !== w.data[107:89])
            report("new_second_y", signed'(data[107:89]), signed'(w.data[107:89]));
        if (data[123:108] !== w.data[123:108])
            report("new_second_vx", signed'(data[123:108]), signed'(w.data[123:108]));
        if (data[139:124] !== w.data[139:124])
            report("new_second_vy", signed'(data[139:124]), signed'(w.data[139:124]));
        if (data[155:140] !== w.data[155:140])
            report("normal_x", signed'(data[155:140]), signed'(w.data[155:140]));
        if (data[171:156] !== w.data[171:156])
            report("normal_y", signed'(data[171:156]), signed'(w.data[171:156]));
        if (data[175:172] !== 4'd0)
            report("padding", data[175:172], 0);
        if (flags[0] !== w.flags[0]) report("contact", flags[0], w.flags[0]);
        if (flags[1] !== w.flags[1]) report("impact", flags[1], w.flags[1]);
        checked++;
    endfunction
endclass

module tb_top;
    import cpcr_pkg::*;

    localparam int LATENCY  = 47;
    localparam int WATCHDOG = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [175:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [175:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         i_psel = 1'b0;
    logic         i_penable = 1'b0;
    logic         i_pwrite = 1'b0;
    logic [2:0]   i_paddr = '0;
    logic [31:0]  i_pwdata = '0;
    logic [31:0]  o_prdata;
    logic         o_pready;

    collision_scoreboard sb = new();
    t_pair  in_flight[$];
    bit     hold_off = 0;
    bit     no_idle = 0;
    int     quiet = 0;
    int     sent = 0;
    int     settings_used = 0;

    circle_pair_collision_response u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Accepted requests feed the predictor; accepted results are checked.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) sb.note_request(in_flight.pop_front());
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("watchdog expired after %0d idle cycles", quiet);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off when asked.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_m_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 20);
                i_m_tready <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic write_restitution(int unsigned value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= REG_RESTITUTION;
        i_pwdata <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk iff o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        sb.restitution = value & 9'h1FF;
        settings_used++;
    endtask

    // The sender stops offering and waits until every result has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0 || in_flight.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Valid stays high between back-to-back requests and only drops for an idle burst.
    task automatic send_pair(t_pair p);
        int n;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_flight.push_back(p);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {4'd0, p.r2, p.vy2, p.vx2, p.y2, p.x2, p.r1, p.vy1, p.vx1, p.y1, p.x1};
        @(posedge i_clk iff o_s_tready);
        sent++;
    endtask

    function automatic t_pair fully_random();
        t_pair p;
        logic [191:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = bits[171:0];
        return p;
    endfunction

    // Mostly overlapping pairs with random offsets, sizes and velocities.
    function automatic t_pair touching_pair(int kind);
        t_pair p;
        int span;
        p = fully_random();
        span = (kind == 0) ? 255 : ((kind == 1) ? 4095 : 65535);
        p.x1 = 19'($urandom_range(0, 524287) - 262144);
        p.y1 = 19'($urandom_range(0, 524287) - 262144);
        p.r1 = 16'($urandom_range(0, span));
        p.r2 = 16'($urandom_range(0, span));
        p.x2 = 19'(p.x1 + int'($urandom_range(0, 2 * span)) - span);
        p.y2 = 19'(p.y1 + int'($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 3) == 0) begin
            p.vx1 = 16'($urandom_range(0, 255) - 128);
            p.vy1 = 16'($urandom_range(0, 255) - 128);
        end
        return p;
    endfunction

    function automatic t_pair make_pair(int x1, int y1, int vx1, int vy1, int r1,
                                        int x2, int y2, int vx2, int vy2, int r2);
        t_pair p;
        p.x1 = 19'(x1); p.y1 = 19'(y1); p.vx1 = 16'(vx1); p.vy1 = 16'(vy1);
        p.r1 = 16'(r1);
        p.x2 = 19'(x2); p.y2 = 19'(y2); p.vx2 = 16'(vx2); p.vy2 = 16'(vy2);
        p.r2 = 16'(r2);
        return p;
    endfunction

    initial begin
        int k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset restitution.
        send_pair(make_pair(0, 0, 0, 0, 256, 10000, 0, 0, 0, 256));          // apart
        send_pair(make_pair(0, 0, 2048, 0, 1024, 0, 0, 0, 0, 1024));        // coincident
        send_pair(make_pair(0, 0, 0, 0, 1024, 5, 5, 0, 0, 1024));           // d2 below limit
        send_pair(make_pair(0, 0, 0, 0, 1024, 6, 5, 0, 0, 1024));           // d2 just below limit
        send_pair(make_pair(0, 0, 2048, 0, 512, 512, 0, -2048, 0, 512));    // head-on impact
        send_pair(make_pair(0, 0, -2048, 0, 512, 512, 0, 2048, 0, 512));    // separating
        send_pair(make_pair(0, 0, 100, 100, 512, 0, 512, 100, 100, 512));   // at rest on normal
        send_pair(make_pair(-262144, -262144, -32768, -32768, 65535,
                            -262000, -262100, 32767, 32767, 65535));        // saturation low
        send_pair(make_pair(262143, 262143, 32767, 32767, 65535,
                            262000, 262100, -32768, -32768, 65535));        // saturation high
        send_pair(make_pair(-262144, 262143, 32767, -32768, 65535,
                            262143, -262144, -32768, 32767, 65535));        // extreme offset
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(-300, 400, 3000, -4000, 300, 300, -400, -3000, 4000, 500));
        send_pair(make_pair(0, 0, 32767, 32767, 700, 0, 300, -32768, -32768, 700));
        wait_drained();

        // Register extremes, including values above elastic.
        for (k = 0; k < 4; k++) begin
            write_restitution(k == 0 ? 0 : (k == 1 ? 256 : (k == 2 ? 511 : 257)));
            send_pair(make_pair(0, 0, 2048, 0, 512, 512, 0, -2048, 0, 512));
            send_pair(make_pair(0, 0, 32767, -32768, 700, 300, 300, -32768, 32767, 700));
            wait_drained();
        end

        // Random part across several settings.
        for (k = 0; k < 440; k++) begin
            if (k % 110 == 0) begin
                wait_drained();
                write_restitution(k == 220 ? 511 : $urandom_range(0, 300));
            end
            if (k == 150) hold_off = 1;
            if (k == 300) wait_drained();
            if (k == 380) no_idle = 1;
            if ($urandom_range(0, 9) == 0) send_pair(fully_random());
            else send_pair(touching_pair($urandom_range(0, 2)));
        end
        wait_drained();

        $display("%0d pairs sent, %0d contacts, %0d impacts, %0d restitution settings",
                 sent, sb.contacts, sb.impacts, settings_used);
        $display("results checked: %0d, mismatches: %0d", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/cpcr_pkg.sv
rtl/cpcr_sqrt.sv
rtl/cpcr_div.sv
rtl/circle_pair_collision_response.sv
rtl/cpcr_checker.sv
tb/tb_top.sv
